// ===== hdl/cnf12_pkg.sv =====
// Shared constants, types and helper functions of the cellular noise F1/F2 core.
`timescale 1ns / 1ps

package cnf12_pkg;

  // Default number of fraction bits of the sample coordinates.
  localparam int COORD_FRAC_BITS = 16;

  // Hash constants in Q.32: multiplier 0.1031 and offset 33.33.
  localparam logic [31:0] HK_MUL = 32'd442811128;
  localparam logic [37:0] HK_ADD = 38'd143151259976;

  // The second hash argument is offset by 19.19 and 47.47: integer part here.
  localparam logic [31:0] HK_OX_HI = 32'd19;
  localparam logic [31:0] HK_OY_HI = 32'd47;

  // Carry of the offset fraction times the multiplier into the upper word.
  localparam logic [31:0] HK_CX = 32'((64'd816043786 * 64'd442811128) >> 32);
  localparam logic [31:0] HK_CY = 32'((64'd2018634629 * 64'd442811128) >> 32);

  // Squared distances are Q.60 and below 2^63.
  localparam int SQD_W = 63;

  // Square root: radicand is the squared distance without its low 28 bits.
  localparam int SQ_IN_W   = 36;
  localparam int SQ_OUT_W  = 18;
  localparam int SQ_REM_W  = SQ_OUT_W + 2;
  localparam int SQ_PER    = 3;
  localparam int SQ_STAGES = SQ_OUT_W / SQ_PER;

  // Two smallest squared distances of a group of candidates.
  typedef struct packed {
    logic [SQD_W-1:0] lo;
    logic [SQD_W-1:0] hi;
  } pair_t;

  // Working state of the digit-by-digit square root.
  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_OUT_W-1:0] root;
    logic [SQ_IN_W-1:0]  rad;
  } sq_t;

  // Merge two candidate pairs into the two smallest values of their union.
  function automatic pair_t pair_merge(pair_t a, pair_t b);
    pair_t m;
    if (a.lo <= b.lo) begin
      m.lo = a.lo;
      m.hi = (a.hi < b.lo) ? a.hi : b.lo;
    end else begin
      m.lo = b.lo;
      m.hi = (b.hi < a.lo) ? b.hi : a.lo;
    end
    return m;
  endfunction

  // One result bit of the restoring square root.
  function automatic sq_t sq_step(sq_t x);
    sq_t                 y;
    logic [SQ_REM_W+1:0] rem2;
    logic [SQ_REM_W+1:0] trial;
    rem2  = {x.rem, x.rad[SQ_IN_W-1 -: 2]};
    trial = {2'b00, x.root, 2'b01};
    y.rad = {x.rad[SQ_IN_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      y.rem  = SQ_REM_W'(rem2 - trial);
      y.root = {x.root[SQ_OUT_W-2:0], 1'b1};
    end else begin
      y.rem  = rem2[SQ_REM_W-1:0];
      y.root = {x.root[SQ_OUT_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

// ===== hdl/cnf12_sqrt.sv =====
// Pipelined integer square root, a few result bits per stage.
`timescale 1ns / 1ps

module cnf12_sqrt (
  input  logic                                 clk,
  input  logic [cnf12_pkg::SQ_STAGES-1:0]      en,
  input  logic [cnf12_pkg::SQ_IN_W-1:0]        din,
  output logic [cnf12_pkg::SQ_OUT_W-1:0]       dout
);

  cnf12_pkg::sq_t stg_r   [cnf12_pkg::SQ_STAGES];
  cnf12_pkg::sq_t stg_nxt [cnf12_pkg::SQ_STAGES];

  for (genvar k = 0; k < cnf12_pkg::SQ_STAGES; k++) begin : g_stg
    // Each stage resolves a fixed group of result bits.
    always_comb begin
      cnf12_pkg::sq_t x;
      if (k == 0) begin
        x.rem  = '0;
        x.root = '0;
        x.rad  = din;
      end else begin
        x = stg_r[(k > 0) ? k - 1 : 0];
      end
      for (int s = 0; s < cnf12_pkg::SQ_PER; s++) begin
        x = cnf12_pkg::sq_step(x);
      end
      stg_nxt[k] = x;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign dout = stg_r[cnf12_pkg::SQ_STAGES-1].root;

endmodule

// ===== hdl/cellular_noise_f1_f2_core.sv =====
// Top level of the cellular noise core: hashing, distances, selection and roots.
//
//  channel | dir | tdata fields (lowest bit up)                    | tuser / tlast
//  in_     | in  | sample_x[31:0], sample_y[63:32]                 | none
//  out_    | out | nearest_dist[17:0], second_dist[35:18],         | none
//          |     | edge_dist[53:36], zero fill[55:54]              |
//
// One transaction is taken per cycle while in_tready is high, that is, unless the pipeline is full and stalled.
// The pipeline has nine stages of hashing, four of distance,
// four of F1/F2 selection, six of square root and the output register.
// Each stage holds its data while the next one is full and stalled, so
// bubbles close up and input is taken while a result waits at the output.
// Reset clears only the valid bits of the stages.
`timescale 1ns / 1ps

module cellular_noise_f1_f2_core #(
  parameter int COORD_FRAC_BITS = cnf12_pkg::COORD_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_x, sample_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // nearest_dist, second_dist, edge_dist, zero fill
);

  // Stage numbers.
  localparam int S_UHI  = 1;
  localparam int S_MUL  = 2;
  localparam int S_ADD  = 3;
  localparam int S_PRD  = 4;
  localparam int S_DSUM = 5;
  localparam int S_UV   = 6;
  localparam int S_FIN  = 7;
  localparam int S_HASH = 8;
  localparam int S_OFS  = 9;
  localparam int S_MAG  = 10;
  localparam int S_SQ   = 11;
  localparam int S_SUM  = 12;
  localparam int S_T1   = 13;
  localparam int S_T2   = 14;
  localparam int S_T3   = 15;
  localparam int S_T4   = 16;
  localparam int S_RT   = 17;
  localparam int S_OUT  = S_RT + cnf12_pkg::SQ_STAGES;
  localparam int NSTG   = S_OUT + 1;
  localparam int NCELL  = 9;
  localparam int NHASH  = 2 * NCELL;
  localparam int SD     = cnf12_pkg::SQD_W;

  // Stage valid bits and the ready chain.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   rdy;

  assign rdy[NSTG] = out_tready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = ~vld_r[k] | rdy[k+1];
  end

  always_comb begin
    vld_nxt = (rdy[NSTG-1:0] & {vld_r[NSTG-2:0], in_tvalid}) | (~rdy[NSTG-1:0] & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTG-1];

  // Stage 0: split the sample into cell index and fraction.
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic        [31:0] nx_r;
  logic        [31:0] ny_r;
  logic        [31:0] fxd_r [S_HASH+1];
  logic        [31:0] fyd_r [S_HASH+1];

  assign sx = $signed(in_tdata[31:0]);
  assign sy = $signed(in_tdata[63:32]);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      nx_r     <= 32'(sx >>> COORD_FRAC_BITS);
      ny_r     <= 32'(sy >>> COORD_FRAC_BITS);
      fxd_r[0] <= {sx[COORD_FRAC_BITS-1:0], {(32-COORD_FRAC_BITS){1'b0}}};
      fyd_r[0] <= {sy[COORD_FRAC_BITS-1:0], {(32-COORD_FRAC_BITS){1'b0}}};
    end
  end

  // The fractions travel along with the hash stages.
  for (genvar k = 1; k <= S_HASH; k++) begin : g_fdly
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        fxd_r[k] <= fxd_r[k-1];
        fyd_r[k] <= fyd_r[k-1];
      end
    end
  end

  // Stage 1: upper words of the hash arguments of the neighbor columns and rows.
  logic [31:0] ux_r [3];
  logic [31:0] uy_r [3];
  logic [31:0] uxo_r [3];
  logic [31:0] uyo_r [3];

  always_ff @(posedge clk) begin
    if (rdy[S_UHI]) begin
      for (int i = 0; i < 3; i++) begin
        ux_r[i]  <= nx_r + 32'(i) - 32'd1;
        uy_r[i]  <= ny_r + 32'(i) - 32'd1;
        uxo_r[i] <= nx_r + 32'(i) - 32'd1 + cnf12_pkg::HK_OX_HI;
        uyo_r[i] <= ny_r + 32'(i) - 32'd1 + cnf12_pkg::HK_OY_HI;
      end
    end
  end

  // Stage 2: fract(argument * 0.1031) for each column and row.
  logic [31:0] ax_r [3];
  logic [31:0] by_r [3];
  logic [31:0] axo_r [3];
  logic [31:0] byo_r [3];

  always_ff @(posedge clk) begin
    if (rdy[S_MUL]) begin
      for (int i = 0; i < 3; i++) begin
        ax_r[i]  <= 32'(ux_r[i] * cnf12_pkg::HK_MUL);
        by_r[i]  <= 32'(uy_r[i] * cnf12_pkg::HK_MUL);
        axo_r[i] <= 32'(uxo_r[i] * cnf12_pkg::HK_MUL) + cnf12_pkg::HK_CX;
        byo_r[i] <= 32'(uyo_r[i] * cnf12_pkg::HK_MUL) + cnf12_pkg::HK_CY;
      end
    end
  end

  // Hash lanes, two per cell.
  logic [31:0] a3_r  [NHASH];
  logic [31:0] b3_r  [NHASH];
  logic [37:0] aa3_r [NHASH];
  logic [37:0] ba3_r [NHASH];
  logic [31:0] a4_r  [NHASH];
  logic [31:0] b4_r  [NHASH];
  logic [37:0] p1_r  [NHASH];
  logic [37:0] p2_r  [NHASH];
  logic [37:0] p3_r  [NHASH];
  logic [31:0] a5_r  [NHASH];
  logic [31:0] b5_r  [NHASH];
  logic [39:0] d5_r  [NHASH];
  logic [41:0] u6_r  [NHASH];
  logic [40:0] v6_r  [NHASH];
  logic [31:0] t1_r  [NHASH];
  logic [31:0] t2_r  [NHASH];
  logic [31:0] t3_r  [NHASH];
  logic [31:0] hv_r  [NHASH];

  for (genvar h = 0; h < NHASH; h++) begin : g_hash
    localparam int C  = h / 2;
    localparam int HI = C % 3;
    localparam int HJ = C / 3;

    logic [31:0] a_src;
    logic [31:0] b_src;
    logic [69:0] m1;
    logic [69:0] m2;
    logic [69:0] m3;
    logic [63:0] m4;

    if (h % 2 == 0) begin : g_first
      assign a_src = ax_r[HI];
      assign b_src = by_r[HJ];
    end else begin : g_second
      assign a_src = axo_r[HI];
      assign b_src = byo_r[HJ];
    end

    assign m1 = {38'd0, a3_r[h]} * {32'd0, ba3_r[h]};
    assign m2 = {38'd0, b3_r[h]} * {32'd0, aa3_r[h]};
    assign m3 = {38'd0, a3_r[h]} * {32'd0, aa3_r[h]};
    assign m4 = {32'd0, u6_r[h][31:0]} * {32'd0, v6_r[h][31:0]};

    // Stage 3: operands with 33.33 added.
    always_ff @(posedge clk) begin
      if (rdy[S_ADD]) begin
        a3_r[h]  <= a_src;
        b3_r[h]  <= b_src;
        aa3_r[h] <= {6'd0, a_src} + cnf12_pkg::HK_ADD;
        ba3_r[h] <= {6'd0, b_src} + cnf12_pkg::HK_ADD;
      end
    end

    // Stage 4: the three terms of the dot product.
    always_ff @(posedge clk) begin
      if (rdy[S_PRD]) begin
        a4_r[h] <= a3_r[h];
        b4_r[h] <= b3_r[h];
        p1_r[h] <= m1[69:32];
        p2_r[h] <= m2[69:32];
        p3_r[h] <= m3[69:32];
      end
    end

    // Stage 5: dot product sum.
    always_ff @(posedge clk) begin
      if (rdy[S_DSUM]) begin
        a5_r[h] <= a4_r[h];
        b5_r[h] <= b4_r[h];
        d5_r[h] <= 40'(p1_r[h]) + 40'(p2_r[h]) + 40'(p3_r[h]);
      end
    end

    // Stage 6: (p.x + p.y) and p.z.
    always_ff @(posedge clk) begin
      if (rdy[S_UV]) begin
        u6_r[h] <= {10'd0, a5_r[h]} + {10'd0, b5_r[h]} + {1'b0, d5_r[h], 1'b0};
        v6_r[h] <= {9'd0, a5_r[h]} + {1'b0, d5_r[h]};
      end
    end

    // Stage 7: partial products of the final multiply, fraction word only.
    always_ff @(posedge clk) begin
      if (rdy[S_FIN]) begin
        t1_r[h] <= 32'({22'd0, u6_r[h][41:32]} * v6_r[h][31:0]);
        t2_r[h] <= 32'(u6_r[h][31:0] * {23'd0, v6_r[h][40:32]});
        t3_r[h] <= m4[63:32];
      end
    end

    // Stage 8: hash value in [0,1).
    always_ff @(posedge clk) begin
      if (rdy[S_HASH]) begin
        hv_r[h] <= t1_r[h] + t2_r[h] + t3_r[h];
      end
    end
  end

  // Distance lanes, one per cell.
  logic signed [34:0] dx_r [NCELL];
  logic signed [34:0] dy_r [NCELL];
  logic        [30:0] mx_r [NCELL];
  logic        [30:0] my_r [NCELL];
  logic        [61:0] qx_r [NCELL];
  logic        [61:0] qy_r [NCELL];
  logic     [SD-1:0]  s_r  [NCELL];

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    localparam logic signed [34:0] OFS_X = 35'(signed'((c % 3) - 1)) <<< 32;
    localparam logic signed [34:0] OFS_Y = 35'(signed'((c / 3) - 1)) <<< 32;

    logic signed [34:0] ndx;
    logic signed [34:0] ndy;

    assign ndx = -dx_r[c];
    assign ndy = -dy_r[c];

    // Stage 9: signed offset from sample to feature point.
    always_ff @(posedge clk) begin
      if (rdy[S_OFS]) begin
        dx_r[c] <= OFS_X + $signed({3'd0, hv_r[2*c]}) - $signed({3'd0, fxd_r[S_HASH]});
        dy_r[c] <= OFS_Y + $signed({3'd0, hv_r[2*c+1]}) - $signed({3'd0, fyd_r[S_HASH]});
      end
    end

    // Stage 10: magnitude truncated to 30 fraction bits.
    always_ff @(posedge clk) begin
      if (rdy[S_MAG]) begin
        mx_r[c] <= dx_r[c][34] ? ndx[32:2] : dx_r[c][32:2];
        my_r[c] <= dy_r[c][34] ? ndy[32:2] : dy_r[c][32:2];
      end
    end

    // Stage 11: squares.
    always_ff @(posedge clk) begin
      if (rdy[S_SQ]) begin
        qx_r[c] <= mx_r[c] * mx_r[c];
        qy_r[c] <= my_r[c] * my_r[c];
      end
    end

    // Stage 12: squared distance.
    always_ff @(posedge clk) begin
      if (rdy[S_SUM]) begin
        s_r[c] <= SD'(qx_r[c]) + SD'(qy_r[c]);
      end
    end
  end

  // Stages 13 to 16: tree that keeps the two smallest squared distances.
  cnf12_pkg::pair_t n1_r [5];
  cnf12_pkg::pair_t n2_r [3];
  cnf12_pkg::pair_t n3_r [2];
  cnf12_pkg::pair_t n4_r;

  always_ff @(posedge clk) begin
    if (rdy[S_T1]) begin
      for (int i = 0; i < 4; i++) begin
        n1_r[i] <= cnf12_pkg::pair_merge('{lo: s_r[2*i], hi: '1}, '{lo: s_r[2*i+1], hi: '1});
      end
      n1_r[4] <= '{lo: s_r[8], hi: '1};
    end
    if (rdy[S_T2]) begin
      n2_r[0] <= cnf12_pkg::pair_merge(n1_r[0], n1_r[1]);
      n2_r[1] <= cnf12_pkg::pair_merge(n1_r[2], n1_r[3]);
      n2_r[2] <= n1_r[4];
    end
    if (rdy[S_T3]) begin
      n3_r[0] <= cnf12_pkg::pair_merge(n2_r[0], n2_r[1]);
      n3_r[1] <= n2_r[2];
    end
    if (rdy[S_T4]) begin
      n4_r <= cnf12_pkg::pair_merge(n3_r[0], n3_r[1]);
    end
  end

  // Square roots of F1 and F2, radicand scaled down to Q.32.
  logic [cnf12_pkg::SQ_OUT_W-1:0] f1;
  logic [cnf12_pkg::SQ_OUT_W-1:0] f2;

  cnf12_sqrt u_sqrt_f1 (
    .clk  (clk),
    .en   (rdy[S_OUT-1:S_RT]),
    .din  ({1'b0, n4_r.lo[SD-1:28]}),
    .dout (f1)
  );

  cnf12_sqrt u_sqrt_f2 (
    .clk  (clk),
    .en   (rdy[S_OUT-1:S_RT]),
    .din  ({1'b0, n4_r.hi[SD-1:28]}),
    .dout (f2)
  );

  // Output register.
  logic [17:0] nd_r;
  logic [17:0] sd_r;
  logic [17:0] ed_r;

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      nd_r <= f1;
      sd_r <= f2;
      ed_r <= f2 - f1;
    end
  end

  assign out_tdata = {2'b00, ed_r, sd_r, nd_r};

endmodule
